// ===== hdl/ssi_pkg.sv =====
// Shared types, constants and helper functions for the segment set intersection block.
package ssi_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int IP_W    = COORD_W - 8;
    localparam int SEG_W   = 4 * COORD_W;
    localparam int MAX_SEGMENTS_DEF = 64;

    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_TEST  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_OWN_X   = 2'd0;
    localparam logic [1:0] REG_OWN_Y   = 2'd1;
    localparam logic [1:0] REG_OTHER_X = 2'd2;
    localparam logic [1:0] REG_OTHER_Y = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_seg;

    typedef struct packed {
        logic [1:0] cmd;
        t_seg       seg;
        logic       final_test;
    } t_item;

    typedef struct packed {
        t_coord own_x;
        t_coord own_y;
        t_coord other_x;
        t_coord other_y;
    } t_pos;

    // Saturating Q16.8 add.
    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1])
            sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            sat_add = s[COORD_W-1:0];
    endfunction

    // Integer part, truncated toward zero.
    function automatic logic signed [IP_W-1:0] ipart(input t_coord v);
        logic signed [IP_W-1:0] t;
        t = v[COORD_W-1:8];
        if (v[COORD_W-1] && (v[7:0] != 8'd0))
            ipart = t + IP_W'(1);
        else
            ipart = t;
    endfunction

    function automatic t_seg seg_shift(input t_seg s, input t_coord px, input t_coord py);
        t_seg r;
        r.x0 = sat_add(s.x0, px);
        r.y0 = sat_add(s.y0, py);
        r.x1 = sat_add(s.x1, px);
        r.y1 = sat_add(s.y1, py);
        seg_shift = r;
    endfunction

endpackage

// ===== hdl/segment_set_intersection.sv =====
// Top level of the segment set intersection block.
//
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_cmd, i_start_x/y, i_end_x/y, i_final_test
// result  | out       | o_out_valid / i_out_ready  | o_seg_hit, o_any_hit, o_is_last, o_store_full
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A store item passes through the input queue register and then the result register.
// A test item makes the store RAM read port feed one stored segment per cycle
// into a six-stage pair-test pipeline; with an empty store the sequencer goes
// straight to its output state. A clear item produces no result.
// Reset (synchronous, active low) empties the store, clears the sticky hit and
// zeroes the position registers; there is no clearing pass.
// The two-entry input queue keeps taking items until it holds two, also while the
// back end works or the result register waits on i_out_ready.
module segment_set_intersection
    import ssi_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [23:0] i_start_x,
    input  logic signed [23:0] i_start_y,
    input  logic signed [23:0] i_end_x,
    input  logic signed [23:0] i_end_y,
    input  logic               i_final_test,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_seg_hit,
    output logic               o_any_hit,
    output logic               o_is_last,
    output logic               o_store_full,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    t_item in_item, q_item;
    t_pos  r_pos;
    logic  q_valid, q_ready;

    assign in_item.cmd        = i_cmd;
    assign in_item.seg.x0     = i_start_x;
    assign in_item.seg.y0     = i_start_y;
    assign in_item.seg.x1     = i_end_x;
    assign in_item.seg.y1     = i_end_y;
    assign in_item.final_test = i_final_test;

    // Position registers; to be written only while idle (the user's duty, not enforced here), so always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OWN_X:   r_pos.own_x   <= i_cfg_data;
                REG_OWN_Y:   r_pos.own_y   <= i_cfg_data;
                REG_OTHER_X: r_pos.other_x <= i_cfg_data;
                REG_OTHER_Y: r_pos.other_y <= i_cfg_data;
                default:     r_pos         <= r_pos;
            endcase
        end
    end

    ssi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    ssi_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_item     (q_item),
        .i_pos        (r_pos),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_seg_hit    (o_seg_hit),
        .o_any_hit    (o_any_hit),
        .o_is_last    (o_is_last),
        .o_store_full (o_store_full)
    );

endmodule

// ===== hdl/ssi_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ssi_ram #(
    parameter int W = 8,
    parameter int D = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        if (i_re)
            r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ssi_front.sv =====
// Front end: accepts items, drops unused commands, two-entry queue to the back end.
module ssi_front
    import ssi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_q_valid,
    input  logic  i_q_ready,
    output t_item o_q_item
);

    t_item      r_e0, r_e1;
    logic [1:0] r_cnt;
    t_item      n_e0, n_e1;
    logic [1:0] n_cnt;
    logic       push, pop, known;

    always_comb begin
        case (i_item.cmd)
            CMD_STORE, CMD_TEST, CMD_CLEAR: known = 1'b1;
            default:                        known = 1'b0;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_e0;
    assign push      = i_valid && o_ready && known;
    assign pop       = o_q_valid && i_q_ready;

    always_comb begin
        n_e0  = r_e0;
        n_e1  = r_e1;
        n_cnt = r_cnt;
        if (pop && push) begin
            if (r_cnt == 2'd1) begin
                n_e0 = i_item;
            end else begin
                n_e0 = r_e1;
                n_e1 = i_item;
            end
        end else if (pop) begin
            n_e0  = r_e1;
            n_cnt = r_cnt - 2'd1;
        end else if (push) begin
            if (r_cnt == 2'd0)
                n_e0 = i_item;
            else
                n_e1 = i_item;
            n_cnt = r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0 <= n_e0;
        r_e1 <= n_e1;
        if (!i_rst_n)
            r_cnt <= 2'd0;
        else
            r_cnt <= n_cnt;
    end

endmodule

// ===== hdl/ssi_back.sv =====
// Back end: segment store, pair-test pipeline and result register.
module ssi_back
    import ssi_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    output logic  o_q_ready,
    input  t_item i_q_item,
    input  t_pos  i_pos,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output logic  o_seg_hit,
    output logic  o_any_hit,
    output logic  o_is_last,
    output logic  o_store_full
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} t_state;

    t_state     r_state, n_state;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx;
    logic       r_hit_seen, n_hit_seen;
    logic       r_last, n_last;
    t_seg       r_q, n_q;
    logic       r_out_valid, n_out_valid;
    logic       r_seg_hit, n_seg_hit, r_any_hit, n_any_hit;
    logic       r_is_last, n_is_last, r_store_full, n_store_full;
    logic       slot_free, rd_en, we, clr_hit;

    logic [SEG_W-1:0] rdata;
    logic [4:0]       r_pv;
    t_seg             r_p;
    logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy;
    logic signed [DIFF_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic             box_ok, r_box2, r_box3, r_box4;
    logic signed [PROD_W-1:0] r_bycx, r_bxcy, r_aybx, r_axby, r_axcy, r_aycx;
    logic signed [SUM_W-1:0]  r_d, r_e, r_f;
    logic             num_ok, r_hit;
    logic signed [IP_W-1:0] lo, hi;
    logic             rej_x, rej_y;

    ssi_ram #(.W(SEG_W), .D(MAX_SEGMENTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_q_item.seg),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign rd_en     = (r_state == S_RUN);

    // Control sequencer.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_hit_seen   = r_hit_seen;
        n_last       = r_last;
        n_q          = r_q;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_seg_hit    = r_seg_hit;
        n_any_hit    = r_any_hit;
        n_is_last    = r_is_last;
        n_store_full = r_store_full;
        o_q_ready    = 1'b0;
        we           = 1'b0;
        clr_hit      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.cmd)
                        CMD_STORE: begin
                            if (slot_free) begin
                                o_q_ready    = 1'b1;
                                n_out_valid  = 1'b1;
                                n_seg_hit    = 1'b0;
                                n_is_last    = 1'b0;
                                n_any_hit    = r_hit_seen;
                                n_store_full = (r_count == CW'(MAX_SEGMENTS));
                                if (r_count != CW'(MAX_SEGMENTS)) begin
                                    we      = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        CMD_TEST: begin
                            o_q_ready = 1'b1;
                            clr_hit   = 1'b1;
                            n_last    = i_q_item.final_test;
                            n_q       = seg_shift(i_q_item.seg, i_pos.other_x, i_pos.other_y);
                            n_idx     = '0;
                            n_state   = (r_count == '0) ? S_OUT : S_RUN;
                        end
                        CMD_CLEAR: begin
                            o_q_ready  = 1'b1;
                            n_count    = '0;
                            n_hit_seen = 1'b0;
                        end
                        default: o_q_ready = 1'b1;
                    endcase
                end
            end
            S_RUN: begin
                n_idx = r_idx + CW'(1);
                if (r_idx == r_count - CW'(1))
                    n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (r_pv == '0)
                    n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_seg_hit    = r_hit;
                    n_any_hit    = r_hit_seen || r_hit;
                    n_hit_seen   = r_hit_seen || r_hit;
                    n_is_last    = r_last;
                    n_store_full = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_hit_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_hit_seen  <= n_hit_seen;
            r_out_valid <= n_out_valid;
        end
        r_last       <= n_last;
        r_q          <= n_q;
        r_seg_hit    <= n_seg_hit;
        r_any_hit    <= n_any_hit;
        r_is_last    <= n_is_last;
        r_store_full <= n_store_full;
    end

    // Bounding box on integer parts.
    always_comb begin
        if (r_p.x1 < r_p.x0) begin lo = ipart(r_p.x1); hi = ipart(r_p.x0); end
        else begin lo = ipart(r_p.x0); hi = ipart(r_p.x1); end
        if (r_q.x0 > r_q.x1)
            rej_x = (hi < ipart(r_q.x1)) || (ipart(r_q.x0) < lo);
        else
            rej_x = (hi < ipart(r_q.x0)) || (ipart(r_q.x1) < lo);
    end

    logic signed [IP_W-1:0] loy, hiy;
    always_comb begin
        if (r_p.y1 < r_p.y0) begin loy = ipart(r_p.y1); hiy = ipart(r_p.y0); end
        else begin loy = ipart(r_p.y0); hiy = ipart(r_p.y1); end
        if (r_q.y0 > r_q.y1)
            rej_y = (hiy < ipart(r_q.y1)) || (ipart(r_q.y0) < loy);
        else
            rej_y = (hiy < ipart(r_q.y0)) || (ipart(r_q.y1) < loy);
    end

    assign box_ok = !rej_x && !rej_y;
    assign ax = DIFF_W'(r_p.x1) - DIFF_W'(r_p.x0);
    assign ay = DIFF_W'(r_p.y1) - DIFF_W'(r_p.y0);
    assign bx = DIFF_W'(r_q.x0) - DIFF_W'(r_q.x1);
    assign by = DIFF_W'(r_q.y0) - DIFF_W'(r_q.y1);
    assign cx = DIFF_W'(r_p.x0) - DIFF_W'(r_q.x0);
    assign cy = DIFF_W'(r_p.y0) - DIFF_W'(r_q.y0);

    always_comb begin
        if (r_f > 0)
            num_ok = (r_d >= 0) && (r_d <= r_f) && (r_e >= 0) && (r_e <= r_f);
        else
            num_ok = (r_d <= 0) && (r_d >= r_f) && (r_e <= 0) && (r_e >= r_f);
    end

    // Pair pipeline: read, shift, differences, products, numerators, compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pv <= '0;
        else
            r_pv <= {r_pv[3:0], rd_en};
        r_p    <= seg_shift(t_seg'(rdata), i_pos.own_x, i_pos.own_y);
        r_ax   <= ax;  r_ay <= ay;  r_bx <= bx;
        r_by   <= by;  r_cx <= cx;  r_cy <= cy;
        r_box2 <= box_ok;
        r_bycx <= PROD_W'(r_by * r_cx);
        r_bxcy <= PROD_W'(r_bx * r_cy);
        r_aybx <= PROD_W'(r_ay * r_bx);
        r_axby <= PROD_W'(r_ax * r_by);
        r_axcy <= PROD_W'(r_ax * r_cy);
        r_aycx <= PROD_W'(r_ay * r_cx);
        r_box3 <= r_box2;
        r_d    <= SUM_W'(r_bycx) - SUM_W'(r_bxcy);
        r_f    <= SUM_W'(r_aybx) - SUM_W'(r_axby);
        r_e    <= SUM_W'(r_axcy) - SUM_W'(r_aycx);
        r_box4 <= r_box3;
        if (clr_hit)
            r_hit <= 1'b0;
        else if (r_pv[4] && r_box4 && num_ok)
            r_hit <= 1'b1;
    end

    assign o_out_valid  = r_out_valid;
    assign o_seg_hit    = r_seg_hit;
    assign o_any_hit    = r_any_hit;
    assign o_is_last    = r_is_last;
    assign o_store_full = r_store_full;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS))
        else $error("store count beyond capacity");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_idx < r_count))
        else $error("read index past stored count");
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pv == '0))
        else $error("pair pipeline busy while idle");
    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && slot_free && r_hit) |=> (r_hit_seen && o_seg_hit))
        else $error("hit not recorded");
`endif

endmodule
